// ===== rtl/rmsef_pkg.sv =====
// ----------------------------------------------------------------------------
// rmsef_pkg
// shared constants, register codes and controller types of the rms envelope
// follower
// ----------------------------------------------------------------------------
package rmsef_pkg;

    // default parameter values
    localparam int unsigned DEF_MAX_FRAMES  = 1024;
    localparam int unsigned DEF_SAMPLE_BITS = 16;

    // fixed field widths
    localparam int unsigned KEEP_W = 16;
    localparam int unsigned LVL_W  = 16;
    localparam int unsigned IDX_W  = 2;

    // configuration register indexes
    localparam logic [IDX_W-1:0] CFG_ATTACK_KEEP  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_RELEASE_KEEP = 2'd1;

    // register reset values, q0.16
    localparam logic [KEEP_W-1:0] ATTACK_KEEP_RST  = 16'd13107;
    localparam logic [KEEP_W-1:0] RELEASE_KEEP_RST = 16'd60293;

    // full scale of an unsigned q1.15 level
    localparam logic [LVL_W-1:0] LEVEL_FULL = 16'd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACC,
        ST_CHK,
        ST_DIV,
        ST_SQL,
        ST_SQRT,
        ST_MULA,
        ST_MULB,
        ST_UPD
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic add;
        logic zero;
        logic div_load;
        logic div_step;
        logic sqrt_load;
        logic sqrt_step;
        logic mul_env;
        logic mul_rms;
        logic update;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic pkt_empty;
        logic last;
        logic out_full;
    } t_sts;

endpackage

// ===== rtl/rmsef_in_if.sv =====
// ----------------------------------------------------------------------------
// rmsef_in_if
// sample channel: valid/ready with sample, silent and last
// ----------------------------------------------------------------------------
interface rmsef_in_if
    import rmsef_pkg::*;
#(
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          silent;
    logic                          last;

    modport source (output valid, output sample, output silent, output last, input ready);
    modport sink   (input valid, input sample, input silent, input last, output ready);
endinterface

// ===== rtl/rmsef_out_if.sv =====
// ----------------------------------------------------------------------------
// rmsef_out_if
// result channel: valid/ready with packet rms, level and overflow
// ----------------------------------------------------------------------------
interface rmsef_out_if
    import rmsef_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [LVL_W-1:0] packet_rms;
    logic [LVL_W-1:0] level;
    logic             overflow;

    modport source (output valid, output packet_rms, output level, output overflow,
                    input ready);
    modport sink   (input valid, input packet_rms, input level, input overflow,
                    output ready);
endinterface

// ===== rtl/rmsef_dp.sv =====
// ----------------------------------------------------------------------------
// rmsef_dp
// datapath: square and accumulate, restoring divider, digit-by-digit square
// root, shared multiplier for the envelope update, result register
// ----------------------------------------------------------------------------
module rmsef_dp
    import rmsef_pkg::*;
#(
    parameter int unsigned MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_silent,
    input  logic                   i_last,
    input  logic                   i_cfg_we,
    input  logic [IDX_W-1:0]       i_cfg_idx,
    input  logic [KEEP_W-1:0]      i_cfg_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [LVL_W-1:0]       o_out_rms,
    output logic [LVL_W-1:0]       o_out_level,
    output logic                   o_out_overflow
);
    localparam int unsigned SB     = SAMPLE_BITS;
    localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int unsigned SQ_W   = 2 * SB - 1;
    localparam int unsigned SUM_W  = CNT_W + 2 * SB - 2;
    localparam int unsigned RAD_W  = 2 * SB;
    localparam int unsigned REM_W  = SB + 2;
    localparam int unsigned PROD_W = 2 * LVL_W + 1;
    localparam int unsigned ACC_W  = PROD_W + 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);

    // configuration
    logic [KEEP_W-1:0] r_attack;
    logic [KEEP_W-1:0] r_release;

    // per packet state
    logic [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0] r_cnt;
    logic             r_silent;
    logic             r_drop;
    logic             r_last;
    logic             r_add;
    logic [SQ_W-1:0]  r_sq;

    // divider and root
    logic [SUM_W-1:0] r_div;
    logic [CNT_W-1:0] r_rem;
    logic [RAD_W-1:0] r_rad;
    logic [SB-1:0]    r_srem;
    logic [SB-1:0]    r_root;

    // envelope
    logic [LVL_W-1:0]  r_env;
    logic [PROD_W-1:0] r_p1;
    logic [PROD_W-1:0] r_p2;

    // result register
    logic             r_out_valid;
    logic [LVL_W-1:0] r_out_rms;
    logic [LVL_W-1:0] r_out_lvl;
    logic             r_out_ovf;

    logic [SB-1:0]     w_mag;
    logic [RAD_W-1:0]  w_mag_x;
    logic [RAD_W-1:0]  w_sq;
    logic [CNT_W:0]    w_rem_sh;
    logic              w_qbit;
    logic [REM_W-1:0]  w_srem_sh;
    logic [REM_W-1:0]  w_trial;
    logic              w_rbit;
    logic [LVL_W-1:0]  w_rms;
    logic              w_attack;
    logic [KEEP_W-1:0] w_keep;
    logic [KEEP_W:0]   w_inv;
    logic [LVL_W-1:0]  w_ma;
    logic [KEEP_W:0]   w_mb;
    logic [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]  w_blend;
    logic [ACC_W-17:0] w_next;
    logic [LVL_W-1:0]  w_lvl;

    // square of the sample magnitude; the most negative code maps to 2^(sb-1)
    assign w_mag   = i_sample[SB-1] ? ((~i_sample) + 1'b1) : i_sample;
    assign w_mag_x = RAD_W'(w_mag);
    assign w_sq    = w_mag_x * w_mag_x;

    // restoring divide step
    assign w_rem_sh = {r_rem, r_div[SUM_W-1]};
    assign w_qbit   = (w_rem_sh >= {1'b0, r_cnt});

    // root step, two radicand bits at a time
    assign w_srem_sh = {r_srem, r_rad[RAD_W-1 -: 2]};
    assign w_trial   = {r_root, 2'b01};
    assign w_rbit    = (w_srem_sh >= w_trial);

    // rescale root to q1.15
    generate
        if (SB > LVL_W) begin : g_scale_down
            assign w_rms = LVL_W'(r_root >> (SB - LVL_W));
        end else begin : g_scale_up
            assign w_rms = LVL_W'(r_root) << (LVL_W - SB);
        end
    endgenerate

    // attack when the packet rms rises above the envelope
    assign w_attack = (w_rms > r_env);
    assign w_keep   = w_attack ? r_attack : r_release;
    assign w_inv    = (KEEP_W + 1)'(1 << KEEP_W) - {1'b0, w_keep};
    assign w_ma     = i_cmd.mul_env ? r_env : w_rms;
    assign w_mb     = i_cmd.mul_env ? {1'b0, w_keep} : w_inv;
    assign w_prod   = PROD_W'(w_ma) * PROD_W'(w_mb);

    assign w_blend = ACC_W'(r_p1) + ACC_W'(r_p2);
    assign w_next  = w_blend[ACC_W-1:KEEP_W];
    assign w_lvl   = (w_next > (ACC_W-16)'(LEVEL_FULL)) ? LEVEL_FULL : w_next[LVL_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack  <= ATTACK_KEEP_RST;
            r_release <= RELEASE_KEEP_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ATTACK_KEEP:  r_attack  <= i_cfg_data;
                CFG_RELEASE_KEEP: r_release <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum       <= '0;
            r_cnt       <= '0;
            r_silent    <= 1'b0;
            r_drop      <= 1'b0;
            r_env       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                if (i_silent) begin
                    r_silent <= 1'b1;
                end else if (r_cnt < MAX_CNT) begin
                    r_cnt <= r_cnt + 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.add && r_add) begin
                r_sum <= r_sum + SUM_W'(r_sq);
            end
            if (i_cmd.update) begin
                r_env       <= w_lvl;
                r_sum       <= '0;
                r_cnt       <= '0;
                r_silent    <= 1'b0;
                r_drop      <= 1'b0;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_last <= i_last;
            r_add  <= !i_silent && (r_cnt < MAX_CNT);
            r_sq   <= w_sq[SQ_W-1:0];
        end
        if (i_cmd.div_load) begin
            r_div <= r_sum;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_div <= {r_div[SUM_W-2:0], w_qbit};
            r_rem <= w_qbit ? CNT_W'(w_rem_sh - {1'b0, r_cnt}) : w_rem_sh[CNT_W-1:0];
        end
        if (i_cmd.zero) begin
            r_root <= '0;
        end else if (i_cmd.sqrt_load) begin
            r_rad  <= RAD_W'(r_div[SQ_W-1:0]);
            r_srem <= '0;
            r_root <= '0;
        end else if (i_cmd.sqrt_step) begin
            r_rad  <= r_rad << 2;
            r_srem <= w_rbit ? SB'(w_srem_sh - w_trial) : w_srem_sh[SB-1:0];
            r_root <= {r_root[SB-2:0], w_rbit};
        end
        if (i_cmd.mul_env) begin
            r_p1 <= w_prod;
        end
        if (i_cmd.mul_rms) begin
            r_p2 <= w_prod;
        end
        if (i_cmd.update) begin
            r_out_rms <= w_rms;
            r_out_lvl <= w_lvl;
            r_out_ovf <= r_drop;
        end
    end

    assign o_sts.pkt_empty = r_silent || (r_cnt == '0);
    assign o_sts.last      = r_last;
    assign o_sts.out_full  = r_out_valid && !i_out_ready;

    assign o_out_valid    = r_out_valid;
    assign o_out_rms      = r_out_rms;
    assign o_out_level    = r_out_lvl;
    assign o_out_overflow = r_out_ovf;

endmodule

// ===== rtl/rmsef_ctrl.sv =====
// ----------------------------------------------------------------------------
// rmsef_ctrl
// controller: sequences accumulate, divide, root and envelope update
// ----------------------------------------------------------------------------
module rmsef_ctrl
    import rmsef_pkg::*;
#(
    parameter int unsigned MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    localparam int unsigned CNT_W  = $clog2(MAX_FRAMES + 1);
    localparam int unsigned SUM_W  = CNT_W + 2 * SAMPLE_BITS - 2;
    localparam int unsigned STEP_W = $clog2(SUM_W);
    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(SUM_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(SAMPLE_BITS - 1);

    t_state            r_state;
    t_state            n_state;
    logic [STEP_W-1:0] r_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            if (o_cmd.div_load || o_cmd.sqrt_load) begin
                r_step <= '0;
            end else if (o_cmd.div_step || o_cmd.sqrt_step) begin
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_ACC;
                end
            end
            ST_ACC: begin
                o_cmd.add = 1'b1;
                n_state   = i_sts.last ? ST_CHK : ST_IDLE;
            end
            ST_CHK: begin
                if (i_sts.pkt_empty) begin
                    o_cmd.zero = 1'b1;
                    n_state    = ST_MULA;
                end else begin
                    o_cmd.div_load = 1'b1;
                    n_state        = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div_step = 1'b1;
                if (r_step == DIV_LAST) begin
                    n_state = ST_SQL;
                end
            end
            ST_SQL: begin
                o_cmd.sqrt_load = 1'b1;
                n_state         = ST_SQRT;
            end
            ST_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                if (r_step == SQRT_LAST) begin
                    n_state = ST_MULA;
                end
            end
            ST_MULA: begin
                o_cmd.mul_env = 1'b1;
                n_state       = ST_MULB;
            end
            ST_MULB: begin
                o_cmd.mul_rms = 1'b1;
                n_state       = ST_UPD;
            end
            ST_UPD: begin
                if (!i_sts.out_full) begin
                    o_cmd.update = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/rms_envelope_follower.sv =====
// ----------------------------------------------------------------------------
// rms_envelope_follower
// per-packet rms of q1.15 audio with an attack/release smoothed level
// ----------------------------------------------------------------------------
// usage
//   i_in carries one sample per transaction with silent and last flags; the
//   transaction with last set closes a packet and yields one result on o_out
//   (packet_rms, level, overflow). other transactions yield no result.
//   i_cfg_we/i_cfg_idx/i_cfg_data write attack_keep (0) and release_keep (1);
//   others ignored; the user writes only while the block is idle (unchecked).
// samples
//   a sample is accepted (square computed by one multiplier) and then
//   accumulated; the next sample is not taken before the accumulate state.
// sequence at packet end
//   accumulate, check, restoring divide one bit a cycle over the sum
//   width (clog2(MAX_FRAMES+1) + 2*SAMPLE_BITS - 2, 41 at the defaults),
//   root load, root one bit a cycle (SAMPLE_BITS bits), two products on the
//   shared envelope multiplier and the update. an empty or silent packet
//   skips divide and root.
// reset
//   synchronous active low; clears the envelope, the packet sum, count and
//   silent/drop flags and the result valid flag; restores both keep registers.
// stalls
//   the result sits in an output register; the next packet's samples are
//   still taken while it waits, and only the following packet end holds
//   in its update cycle until o_out.ready frees the register
// ----------------------------------------------------------------------------
module rms_envelope_follower
    import rmsef_pkg::*;
#(
    parameter int unsigned MAX_FRAMES  = DEF_MAX_FRAMES,
    parameter int unsigned SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    rmsef_in_if.sink          i_in,
    rmsef_out_if.source       o_out,
    input  logic              i_cfg_we,
    input  logic [IDX_W-1:0]  i_cfg_idx,
    input  logic [KEEP_W-1:0] i_cfg_data
);
    // command and status between controller and datapath
    t_cmd w_cmd;
    t_sts w_sts;

    // sequencer: sample accept, packet-end divide and root, envelope update
    rmsef_ctrl #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // arithmetic, packet state, keep registers and the result register
    rmsef_dp #(
        .MAX_FRAMES  (MAX_FRAMES),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_sts          (w_sts),
        .i_sample       (i_in.sample),
        .i_silent       (i_in.silent),
        .i_last         (i_in.last),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .o_out_valid    (o_out.valid),
        .i_out_ready    (o_out.ready),
        .o_out_rms      (o_out.packet_rms),
        .o_out_level    (o_out.level),
        .o_out_overflow (o_out.overflow)
    );

endmodule

// ===== rtl/rmsef_chk.sv =====
// ----------------------------------------------------------------------------
// rmsef_chk
// port-level checks of the rms envelope follower, bound to the top level
// ----------------------------------------------------------------------------
module rmsef_chk
    import rmsef_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_in_valid,
    input logic             i_in_ready,
    input logic             i_in_last,
    input logic             i_out_valid,
    input logic             i_out_ready,
    input logic [LVL_W-1:0] i_out_rms,
    input logic [LVL_W-1:0] i_out_level,
    input logic             i_out_ovf
);
    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_rms) && $stable(i_out_level) && $stable(i_out_ovf))
        else $error("result changed while stalled");

    // reset empties the result register
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // rms and level never exceed full scale
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_out_rms <= LEVEL_FULL) && (i_out_level <= LEVEL_FULL))
        else $error("result above full scale");

    // a sample that does not close a packet makes no result
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && !i_in_last && !i_out_valid |=> !i_out_valid)
        else $error("result without packet end");

    // every sample passes the accumulate state before the next one is taken
    a_acc_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("sample taken during accumulate");

endmodule

bind rms_envelope_follower rmsef_chk u_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_last   (i_in.last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_rms   (o_out.packet_rms),
    .i_out_level (o_out.level),
    .i_out_ovf   (o_out.overflow)
);
